// ===== hw/rtl/swps_pkg.sv =====
// ----------------------------------------------------------------------------
// swps_pkg: shared types and constants for the peak-spread block
// Widths, register map, scan state encoding and the min/max accumulator type.
// ----------------------------------------------------------------------------
package swps_pkg;

	localparam int WINDOW_MAX_DEF = 256;
	localparam int DATA_W         = 32;
	localparam int WLEN_W         = 9;
	localparam int APB_AW         = 3;
	localparam int APB_DW         = 32;

	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1);

	// register index, taken from the word address bit
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} swps_state_t;

	typedef struct packed {
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] lo;
	} swps_acc_t;

	localparam swps_acc_t ACC_EMPTY = '{hi: '0, lo: '1};

	typedef struct packed {
		logic shift;
		logic clear;
		logic scan;
	} swps_ctl_t;

endpackage

// ===== hw/rtl/swps_in_if.sv =====
// ----------------------------------------------------------------------------
// swps_in_if: sample request channel
// Valid/ready channel carrying one sample and its end-of-sequence mark.
// ----------------------------------------------------------------------------
interface swps_in_if;
	import swps_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] sample;
	logic              last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);

endinterface

// ===== hw/rtl/swps_out_if.sv =====
// ----------------------------------------------------------------------------
// swps_out_if: result request channel
// Valid/ready channel carrying the best spread and the window status flags.
// ----------------------------------------------------------------------------
interface swps_out_if;
	import swps_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] best_spread;
	logic              window_full;
	logic              sequence_end;

	modport source (output valid, output best_spread, output window_full,
		output sequence_end, input ready);
	modport sink (input valid, input best_spread, input window_full,
		input sequence_end, output ready);

endinterface

// ===== hw/rtl/swps_cell.sv =====
// ----------------------------------------------------------------------------
// swps_cell: one window cell
// Holds one sample of the shift line and a running max/min that moves one
// cell toward the head on every scan cycle while the cell is in the window.
// ----------------------------------------------------------------------------
module swps_cell (
	input  logic                      clk,
	input  swps_pkg::swps_ctl_t       ctl,
	input  logic                      in_win,
	input  logic [swps_pkg::DATA_W-1:0] prev_val,
	input  swps_pkg::swps_acc_t       next_acc,
	output logic [swps_pkg::DATA_W-1:0] val,
	output swps_pkg::swps_acc_t       acc
);
	import swps_pkg::*;

	logic [DATA_W-1:0] val_q;
	swps_acc_t         acc_q;
	swps_acc_t         acc_d;

	always_comb begin
		acc_d.hi = (val_q > next_acc.hi) ? val_q : next_acc.hi;
		acc_d.lo = (val_q < next_acc.lo) ? val_q : next_acc.lo;
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= prev_val;
		end
		if (ctl.clear) begin
			acc_q <= ACC_EMPTY;
		end else if (ctl.scan && in_win) begin
			acc_q <= acc_d;
		end
	end

	assign val = val_q;
	assign acc = acc_q;

endmodule

// ===== hw/rtl/swps_chain.sv =====
// ----------------------------------------------------------------------------
// swps_chain: row of window cells
// Cell 0 takes the new sample; the max/min accumulators flow from the far
// end of the active window back to cell 0.
// ----------------------------------------------------------------------------
module swps_chain #(
	parameter int WINDOW_MAX = swps_pkg::WINDOW_MAX_DEF,
	parameter int LW         = $clog2(WINDOW_MAX + 1)
) (
	input  logic                        clk,
	input  swps_pkg::swps_ctl_t         ctl,
	input  logic [swps_pkg::DATA_W-1:0] sample,
	input  logic [LW-1:0]               len,
	output swps_pkg::swps_acc_t         head_acc
);
	import swps_pkg::*;

	logic [DATA_W-1:0] vals [WINDOW_MAX];
	swps_acc_t         accs [WINDOW_MAX];

	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		logic [DATA_W-1:0] prev_v;
		swps_acc_t         next_a;
		logic              in_win;

		if (k == 0) begin : g_head
			assign prev_v = sample;
		end else begin : g_body
			assign prev_v = vals[k-1];
		end

		if (k == WINDOW_MAX - 1) begin : g_tail
			assign next_a = ACC_EMPTY;
		end else begin : g_link
			assign next_a = accs[k+1];
		end

		assign in_win = LW'(k) < len;

		swps_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.in_win   (in_win),
			.prev_val (prev_v),
			.next_acc (next_a),
			.val      (vals[k]),
			.acc      (accs[k])
		);
	end

	assign head_acc = accs[0];

endmodule

// ===== hw/rtl/sliding_window_peak_spread.sv =====
// ----------------------------------------------------------------------------
// sliding_window_peak_spread: best max-minus-min over sliding windows
// Per sample: accept, scan the max/min over L cells, then load the output
//   register, waiting while it holds a result not yet taken; L = window
//   length (0 counts as 1, clamped to WINDOW_MAX). A new sample is taken
//   only in idle, also while a result waits in the output register.
// Reset: control, counts and best spread clear, window length returns to 1;
//   window cells are not cleared and only count toward the result once written.
// ----------------------------------------------------------------------------
module sliding_window_peak_spread #(
	parameter int WINDOW_MAX = swps_pkg::WINDOW_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swps_pkg::APB_AW-1:0] paddr,
	input  logic [swps_pkg::APB_DW-1:0] pwdata,
	output logic [swps_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	swps_in_if.sink                     samples,
	swps_out_if.source                  results
);
	import swps_pkg::*;

	localparam int LW = $clog2(WINDOW_MAX + 1);
	localparam int CW = (LW > WLEN_W) ? LW : WLEN_W;

	logic [WLEN_W-1:0] wlen_q;
	logic [CW-1:0]     wlen_x;
	logic [LW-1:0]     eff_len;

	swps_state_t       st_q, st_d;
	swps_ctl_t         ctl;
	logic              accept;
	logic              load_out;

	logic [LW-1:0]     len_q;
	logic [LW-1:0]     scan_q;
	logic [LW-1:0]     cnt_q;
	logic [LW-1:0]     cnt_next;
	logic              full_q;
	logic              last_q;
	logic [DATA_W-1:0] best_q;
	logic [DATA_W-1:0] spread;
	logic [DATA_W-1:0] best_new;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_best_q;
	logic              out_full_q;
	logic              out_end_q;

	swps_acc_t         head_acc;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? APB_DW'(wlen_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_LENGTH) begin
			wlen_q <= pwdata[WLEN_W-1:0];
		end
	end

	always_comb begin
		wlen_x = CW'(wlen_q);
		if (wlen_x == '0) begin
			eff_len = LW'(1);
		end else if (wlen_x > CW'(WINDOW_MAX)) begin
			eff_len = LW'(WINDOW_MAX);
		end else begin
			eff_len = wlen_x[LW-1:0];
		end
	end

	assign cnt_next = (cnt_q == LW'(WINDOW_MAX)) ? cnt_q : cnt_q + LW'(1);

	swps_chain #(
		.WINDOW_MAX (WINDOW_MAX),
		.LW         (LW)
	) u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.sample   (samples.sample),
		.len      (len_q),
		.head_acc (head_acc)
	);

	assign spread   = head_acc.hi - head_acc.lo;
	assign best_new = (full_q && spread > best_q) ? spread : best_q;

	always_comb begin
		st_d          = st_q;
		ctl           = '0;
		samples.ready = 1'b0;
		load_out      = 1'b0;
		case (st_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					ctl.shift = 1'b1;
					ctl.clear = 1'b1;
					st_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (scan_q == LW'(1)) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || results.ready) begin
					load_out = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign accept = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LW'(1);
			scan_q <= '0;
			cnt_q  <= '0;
			full_q <= 1'b0;
			last_q <= 1'b0;
			best_q <= '0;
		end else begin
			if (accept) begin
				len_q  <= eff_len;
				scan_q <= eff_len;
				full_q <= cnt_next >= eff_len;
				last_q <= samples.last_sample;
				cnt_q  <= samples.last_sample ? '0 : cnt_next;
			end else if (st_q == ST_SCAN) begin
				scan_q <= scan_q - LW'(1);
			end
			if (load_out) begin
				best_q <= last_q ? '0 : best_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_best_q <= best_new;
			out_full_q <= full_q;
			out_end_q  <= last_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.best_spread  = out_best_q;
	assign results.window_full  = out_full_q;
	assign results.sequence_end = out_end_q;

endmodule
